/* rtl/mrfc_pkg.sv */
`timescale 1ns / 1ps

package mrfc_pkg;

   // request kinds carried in req_tuser
   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_REPLY = 2'd2;

   // result kinds carried in rsp_tuser
   localparam logic [2:0] ST_FRAME_OK   = 3'd0;
   localparam logic [2:0] ST_CRC_ERR    = 3'd1;
   localparam logic [2:0] ST_LEN_ERR    = 3'd2;
   localparam logic [2:0] ST_REPLY_OK   = 3'd3;
   localparam logic [2:0] ST_REPLY_BAD  = 3'd4;
   localparam logic [2:0] ST_TIMEOUT    = 3'd5;

   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam int          MIN_FRAME = 4;

   localparam logic [0:0] REG_GAP_TICKS = 1'b0;
   localparam logic [0:0] REG_TIMEOUT   = 1'b1;

   typedef logic [15:0] word_type;

   // one byte of the reflected CRC-16, eight shift steps
   function automatic word_type crc16_byte(input word_type crc, input logic [7:0] data);
      word_type c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* rtl/modbus_rtu_frame_checker_top.sv */
`timescale 1ns / 1ps
// A request beat is caught in the input register when accepted; its result then moves
//   into the result register and onto rsp, once that stage is empty or rsp_tready is high.
// Throughput: one request beat per cycle while rsp_tready stays high; the
//   CRC update, counters and frame checks are combinational between the registers.
// Reset: synchronous, active high; clears the pipeline, flags, counters and IDs,
//   and sets gap_ticks to 5 and response_timeout to 1000.
module modbus_rtu_frame_checker_top #(
   parameter int MAX_FRAME = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] data_byte, [23:8] reply_id
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] txn_id, [23:16] frame_len
   output logic [2:0]  rsp_tuser,   // [2:0] status
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mrfc_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
   localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME);

   // configuration
   logic [15:0] gap_ticks_ff, gap_ticks_in;
   logic [15:0] timeout_ff, timeout_in;

   // input stage
   logic        s_valid_ff, s_valid_in;
   logic [1:0]  s_op_ff;
   logic [7:0]  s_byte_ff;
   logic [15:0] s_rid_ff;

   // result stage
   logic        o_valid_ff, o_valid_in;
   logic [2:0]  o_status_ff, o_status_in;
   logic [15:0] o_id_ff, o_id_in;
   logic [7:0]  o_len_ff, o_len_in;

   // checker state
   logic             busy_ff, busy_in;
   logic             collecting_ff, collecting_in;
   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic [15:0]      crc_ff, crc_in;
   logic [15:0]      gap_count_ff, gap_count_in;
   logic [15:0]      wait_count_ff, wait_count_in;
   logic [15:0]      next_id_ff, next_id_in;
   logic [15:0]      pending_id_ff, pending_id_in;

   logic        advance;
   logic        res_valid;
   logic        cfg_write;
   logic [15:0] gap_limit, wait_limit, gap_inc, wait_inc;
   logic [15:0] crc_base;
   logic [CNT_W-1:0] count_base;

   assign advance    = s_valid_ff && (!o_valid_ff || rsp_tready);
   assign req_tready = !s_valid_ff || advance;
   assign s_valid_in = (req_tvalid && req_tready) || (s_valid_ff && !advance);

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tdata  = {o_len_ff, o_id_ff};
   assign rsp_tuser  = o_status_ff;

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_TIMEOUT) ? {16'h0000, timeout_ff}
                                                     : {16'h0000, gap_ticks_ff};

   always_comb begin
      gap_ticks_in = gap_ticks_ff;
      timeout_in   = timeout_ff;
      if (cfg_write) begin
         if (csr_paddr[2] == REG_GAP_TICKS) begin
            gap_ticks_in = csr_pwdata[15:0];
         end else begin
            timeout_in = csr_pwdata[15:0];
         end
      end
   end

   // zero in a limit register acts as one
   assign gap_limit  = (gap_ticks_ff == 16'd0) ? 16'd1 : gap_ticks_ff;
   assign wait_limit = (timeout_ff == 16'd0) ? 16'd1 : timeout_ff;
   assign gap_inc    = (gap_count_ff == 16'hFFFF) ? gap_count_ff : gap_count_ff + 16'd1;
   assign wait_inc   = (wait_count_ff == 16'hFFFF) ? wait_count_ff : wait_count_ff + 16'd1;
   // a byte after the frame gap starts a fresh frame
   assign crc_base   = collecting_ff ? crc_ff : CRC_INIT;
   assign count_base = collecting_ff ? byte_count_ff : '0;

   always_comb begin
      busy_in       = busy_ff;
      collecting_in = collecting_ff;
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      gap_count_in  = gap_count_ff;
      wait_count_in = wait_count_ff;
      next_id_in    = next_id_ff;
      pending_id_in = pending_id_ff;
      res_valid     = 1'b0;
      o_status_in   = o_status_ff;
      o_id_in       = o_id_ff;
      o_len_in      = o_len_ff;

      if (advance) begin
         case (s_op_ff)
            OP_BYTE: begin
               if (!busy_ff) begin
                  collecting_in = 1'b1;
                  crc_in        = crc16_byte(crc_base, s_byte_ff);
                  byte_count_in = (count_base < CNT_MAX) ? count_base + CNT_W'(1)
                                                         : count_base;
                  gap_count_in  = 16'd0;
               end
            end
            OP_TICK: begin
               if (busy_ff) begin
                  wait_count_in = wait_inc;
                  if (wait_inc >= wait_limit) begin
                     busy_in     = 1'b0;
                     res_valid   = 1'b1;
                     o_status_in = ST_TIMEOUT;
                     o_id_in     = pending_id_ff;
                     o_len_in    = 8'd0;
                  end
               end else if (collecting_ff) begin
                  gap_count_in = gap_inc;
                  if (gap_inc >= gap_limit) begin
                     collecting_in = 1'b0;
                     gap_count_in  = 16'd0;
                     res_valid     = 1'b1;
                     o_id_in       = 16'd0;
                     o_len_in      = 8'd0;
                     if (byte_count_ff < CNT_MIN || byte_count_ff >= CNT_MAX) begin
                        o_status_in = ST_LEN_ERR;
                     end else if (crc_ff != 16'd0) begin
                        o_status_in = ST_CRC_ERR;
                     end else begin
                        o_status_in   = ST_FRAME_OK;
                        o_id_in       = next_id_ff;
                        o_len_in      = 8'(byte_count_ff - CNT_W'(2));
                        pending_id_in = next_id_ff;
                        next_id_in    = next_id_ff + 16'd1;
                        busy_in       = 1'b1;
                        wait_count_in = 16'd0;
                     end
                  end
               end
            end
            OP_REPLY: begin
               if (busy_ff) begin
                  busy_in     = 1'b0;
                  res_valid   = 1'b1;
                  o_status_in = (s_rid_ff == pending_id_ff) ? ST_REPLY_OK : ST_REPLY_BAD;
                  o_id_in     = pending_id_ff;
                  o_len_in    = 8'd0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // hold the result until taken, replace it when the next beat advances
   assign o_valid_in = advance ? res_valid : (o_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ticks_ff  <= 16'd5;
         timeout_ff    <= 16'd1000;
         s_valid_ff    <= 1'b0;
         o_valid_ff    <= 1'b0;
         busy_ff       <= 1'b0;
         collecting_ff <= 1'b0;
         byte_count_ff <= '0;
         crc_ff        <= CRC_INIT;
         gap_count_ff  <= 16'd0;
         wait_count_ff <= 16'd0;
         next_id_ff    <= 16'd0;
         pending_id_ff <= 16'd0;
      end else begin
         gap_ticks_ff  <= gap_ticks_in;
         timeout_ff    <= timeout_in;
         s_valid_ff    <= s_valid_in;
         o_valid_ff    <= o_valid_in;
         busy_ff       <= busy_in;
         collecting_ff <= collecting_in;
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         gap_count_ff  <= gap_count_in;
         wait_count_ff <= wait_count_in;
         next_id_ff    <= next_id_in;
         pending_id_ff <= pending_id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s_op_ff   <= req_tuser;
         s_byte_ff <= req_tdata[7:0];
         s_rid_ff  <= req_tdata[23:8];
      end
      if (advance && res_valid) begin
         o_status_ff <= o_status_in;
         o_id_ff     <= o_id_in;
         o_len_ff    <= o_len_in;
      end
   end

   a_busy_not_collecting : assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && collecting_ff))
      else $error("busy while collecting a frame");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= CNT_MAX)
      else $error("byte count beyond frame limit");

   a_frame_ok_busy : assert property (@(posedge clock) disable iff (reset)
      (advance && res_valid && o_status_in == ST_FRAME_OK)
      |=> (busy_ff && pending_id_ff == $past(next_id_ff) && rsp_tvalid))
      else $error("good frame did not arm the reply wait");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s_valid_ff && o_valid_ff && !rsp_tready))
      else $error("request stalled without a full result stage");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import mrfc_pkg::*;

   localparam int          FRAME_CAP   = 256;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          PHASES      = 8;
   localparam int          PHASE_ITEMS = 178;
   localparam logic [1:0]  OP_UNUSED   = 2'd3;

   typedef struct {
      logic [1:0]  op;
      logic [7:0]  data;
      logic [15:0] rid;
      bit          echo;   // take reply_id from the outstanding transaction at send time
      bit          skew;   // corrupt the echoed ID
   } pending_type;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] txn_id;
      logic [7:0]  frame_len;
   } report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [7:0] data_byte, [23:8] reply_id
   logic [1:0]  req_tuser = '0;   // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // [15:0] txn_id, [23:16] frame_len
   logic [2:0]  rsp_tuser;        // [2:0] status
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pending_type pending_items[$];
   report_type  due_reports[$];
   int          queued_total = 0;
   int          send_gap = 0;
   int          stall_left = 0;
   int          errors = 0;
   int unsigned cycle_count = 0;
   bit          calm = 1'b0;

   // link state as the block should hold it
   logic [15:0] cfg_gap_ticks = 16'd5;
   logic [15:0] cfg_timeout = 16'd1000;
   bit          link_busy = 1'b0;
   bit          link_collecting = 1'b0;
   logic [8:0]  link_count = '0;
   logic [15:0] link_crc = CRC_INIT;
   logic [15:0] link_gap = '0;
   logic [15:0] link_wait = '0;
   logic [15:0] link_next_id = '0;
   logic [15:0] link_pending_id = '0;

   modbus_rtu_frame_checker_top #(.MAX_FRAME(FRAME_CAP)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] octet);
      logic [15:0] c;
      c = acc ^ {8'h00, octet};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   task automatic expect_report(input logic [2:0] status, input logic [15:0] id,
                                input logic [7:0] len);
      report_type r;
      r.status = status;
      r.txn_id = id;
      r.frame_len = len;
      due_reports.push_back(r);
   endtask

   // advance the link state by one accepted beat
   task automatic step_link(input logic [1:0] op, input logic [7:0] data,
                            input logic [15:0] rid);
      logic [15:0] lim;
      logic [8:0]  len;
      case (op)
         OP_BYTE: begin
            if (!link_busy) begin
               if (!link_collecting) begin
                  link_collecting = 1'b1;
                  link_count = '0;
                  link_crc = CRC_INIT;
               end
               link_crc = crc_fold(link_crc, data);
               if (link_count < FRAME_CAP)
                  link_count++;
               link_gap = '0;
            end
         end
         OP_TICK: begin
            if (link_busy) begin
               lim = (cfg_timeout == 0) ? 16'd1 : cfg_timeout;
               if (link_wait != 16'hFFFF)
                  link_wait++;
               if (link_wait >= lim) begin
                  link_busy = 1'b0;
                  expect_report(ST_TIMEOUT, link_pending_id, 8'd0);
               end
            end else if (link_collecting) begin
               lim = (cfg_gap_ticks == 0) ? 16'd1 : cfg_gap_ticks;
               if (link_gap != 16'hFFFF)
                  link_gap++;
               if (link_gap >= lim) begin
                  link_collecting = 1'b0;
                  link_gap = '0;
                  if (link_count < MIN_FRAME || link_count >= FRAME_CAP) begin
                     expect_report(ST_LEN_ERR, 16'd0, 8'd0);
                  end else if (link_crc != 16'h0000) begin
                     expect_report(ST_CRC_ERR, 16'd0, 8'd0);
                  end else begin
                     link_pending_id = link_next_id;
                     link_next_id++;
                     link_busy = 1'b1;
                     link_wait = '0;
                     len = link_count - 9'd2;
                     expect_report(ST_FRAME_OK, link_pending_id, len[7:0]);
                  end
               end
            end
         end
         OP_REPLY: begin
            if (link_busy) begin
               link_busy = 1'b0;
               expect_report((rid == link_pending_id) ? ST_REPLY_OK : ST_REPLY_BAD,
                             link_pending_id, 8'd0);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : req_driver
      pending_type nx;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready)
            step_link(req_tuser, req_tdata[7:0], req_tdata[23:8]);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               nx = pending_items.pop_front();
               // state is current here: every earlier beat has been accepted
               if (nx.echo)
                  nx.rid = link_pending_id ^
                           (nx.skew ? 16'($urandom_range(1, 65535)) : 16'h0000);
               req_tuser <= nx.op;
               req_tdata <= {nx.rid, nx.data};
               req_tvalid <= 1'b1;
               if (!calm && $urandom_range(0, 11) == 0)
                  send_gap = $urandom_range(1, 17);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_reports.size() == 0) begin
               $display("%0t: unexpected beat: expected none, got status %0d id %h len %0d",
                        $time, rsp_tuser, rsp_tdata[15:0], rsp_tdata[23:16]);
               errors++;
            end else begin
               want = due_reports.pop_front();
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_tuser);
                  errors++;
               end
               if (rsp_tdata[15:0] !== want.txn_id) begin
                  $display("%0t: txn_id expected %h, got %h", $time, want.txn_id,
                           rsp_tdata[15:0]);
                  errors++;
               end
               if (rsp_tdata[23:16] !== want.frame_len) begin
                  $display("%0t: frame_len expected %0d, got %0d", $time, want.frame_len,
                           rsp_tdata[23:16]);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("modbus_rtu_frame_checker_top verification failed");
         $finish;
      end
   end

   task automatic queue_item(input logic [1:0] op, input logic [7:0] data,
                             input logic [15:0] rid, input bit echo = 1'b0,
                             input bit skew = 1'b0);
      pending_type p;
      p.op = op;
      p.data = data;
      p.rid = rid;
      p.echo = echo;
      p.skew = skew;
      pending_items.push_back(p);
      queued_total++;
   endtask

   task automatic queue_ticks(input int n);
      repeat (n) queue_item(OP_TICK, 8'($urandom), 16'($urandom));
   endtask

   // payload plus its CRC, low byte first; spoil flips one bit somewhere
   task automatic queue_frame(input int payload, input bit spoil);
      logic [7:0]  body[$];
      logic [15:0] c;
      int          pos;
      c = CRC_INIT;
      for (int i = 0; i < payload; i++) begin
         body.push_back(8'($urandom));
         c = crc_fold(c, body[i]);
      end
      body.push_back(c[7:0]);
      body.push_back(c[15:8]);
      if (spoil) begin
         pos = $urandom_range(0, body.size() - 1);
         body[pos] ^= 8'(1 << $urandom_range(0, 7));
      end
      foreach (body[i])
         queue_item(OP_BYTE, body[i], 16'($urandom));
   endtask

   task automatic queue_exchange();
      int gap_eff;
      int wait_eff;
      int r;
      int n;
      int k;
      gap_eff = (cfg_gap_ticks == 0) ? 1 : cfg_gap_ticks;
      wait_eff = (cfg_timeout == 0) ? 1 : cfg_timeout;
      if ($urandom_range(0, 99) < 18) begin
         repeat ($urandom_range(1, 6))
            queue_item(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom));
      end else begin
         r = $urandom_range(0, 99);
         if (r < 2)
            n = $urandom_range(252, 255);
         else if (r < 10)
            n = $urandom_range(0, 1);
         else
            n = $urandom_range(2, 12);
         queue_frame(n, $urandom_range(0, 4) == 0);
         // end the frame with a silent gap, or part of one when the gap is huge
         queue_ticks((gap_eff > 48) ? $urandom_range(1, 8) : gap_eff + $urandom_range(0, 1));
         r = $urandom_range(0, 99);
         k = (wait_eff > 4) ? 3 : wait_eff - 1;
         if (r < 45) begin
            queue_ticks($urandom_range(0, k));
            queue_item(OP_REPLY, 8'($urandom), 16'h0000, 1'b1, 1'b0);
         end else if (r < 60) begin
            queue_item(OP_REPLY, 8'($urandom), 16'h0000, 1'b1, 1'b1);
         end else if (r < 70) begin
            repeat ($urandom_range(1, 3)) queue_item(OP_BYTE, 8'($urandom), 16'($urandom));
            queue_item(OP_REPLY, 8'($urandom), 16'h0000, 1'b1, 1'b0);
         end else if (r < 85 && wait_eff <= 48) begin
            queue_ticks(wait_eff);
         end
      end
   endtask

   // hold until every beat is sent and every result is back, then let the pipe drain
   task automatic settle();
      do @(posedge clock); while (pending_items.size() != 0 || req_tvalid ||
                                  due_reports.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [0:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_GAP_TICKS)
         cfg_gap_ticks = value;
      else
         cfg_timeout = value;
   endtask

   initial begin
      logic [15:0] gap_set[PHASES];
      logic [15:0] wait_set[PHASES];
      int          phase_end;
      bit          drained;
      gap_set  = '{16'd1, 16'd0, 16'd3, 16'd65535, 16'd2, 16'd0, 16'd0, 16'd0};
      wait_set = '{16'd1, 16'd0, 16'd65535, 16'd4, 16'd12, 16'd0, 16'd0, 16'd0};
      for (int p = 5; p < PHASES; p++) begin
         gap_set[p] = 16'($urandom_range(1, 6));
         wait_set[p] = 16'($urandom_range(1, 30));
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: gap of 5, long response timeout
      queue_item(OP_REPLY, 8'h00, 16'hFFFF);
      queue_item(OP_UNUSED, 8'hFF, 16'hFFFF);
      queue_item(OP_TICK, 8'h00, 16'h0000);
      queue_item(OP_BYTE, 8'h00, 16'h0000);
      queue_item(OP_BYTE, 8'hFF, 16'hFFFF);
      queue_item(OP_BYTE, 8'h55, 16'hAAAA);
      queue_ticks(5);
      queue_frame(2, 1'b0);
      queue_ticks(5);
      queue_item(OP_BYTE, 8'hFF, 16'h5555);
      queue_item(OP_REPLY, 8'h00, 16'h0000, 1'b1, 1'b0);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         csr_write(REG_GAP_TICKS, gap_set[p]);
         csr_write(REG_TIMEOUT, wait_set[p]);
         calm = (p == PHASES - 1);
         phase_end = queued_total + PHASE_ITEMS;
         drained = 1'b0;
         while (queued_total < phase_end) begin
            queue_exchange();
            if (!drained && queued_total >= phase_end - PHASE_ITEMS / 2) begin
               settle();
               drained = 1'b1;
            end
         end
         settle();
      end

      if (due_reports.size() != 0) begin
         $display("%0t: %0d results expected, none arrived", $time, due_reports.size());
         errors++;
      end
      if (errors == 0)
         $display("modbus_rtu_frame_checker_top verification clean");
      else
         $display("modbus_rtu_frame_checker_top verification failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/mrfc_pkg.sv
rtl/modbus_rtu_frame_checker_top.sv
tb/testbench.sv
